[design/button_chord_detector_top_assert.svh]
// ----------------------------------------------------------------------------
// button_chord_detector_top_assert.svh
// Assertion macros shared by the chord detector checkers.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CHORD_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_CHORD_DETECTOR_TOP_ASSERT_SVH

// Clocked check, masked while reset is applied.
`define BCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BCD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/bcd_pkg.sv]
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcd_pkg;

    localparam int CHORDS_DEF = 4;
    localparam int BPC_DEF    = 4;
    localparam int CHORD_REGS = 4;

    localparam int BTN_W      = 8;
    localparam int TIME_W     = 32;
    localparam int SLOTS      = 4;
    localparam int CHORD_W    = 43;
    localparam int CNT_LSB    = 32;
    localparam int CNT_W      = 3;
    localparam int DLY_LSB    = 35;
    localparam int DLY_W      = 8;
    localparam int USED_W     = 4;   // holds chords_in_use saturated to CHORDS
    localparam int CFG_ADDR_W = 3;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_BTN_LSB  = 0;
    localparam int IN_PRESS    = 8;
    localparam int IN_NOW_LSB  = 9;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_W       = 4;

    localparam logic [BTN_W-1:0]  UNSET_BUTTON      = 8'hFF;
    localparam logic [TIME_W-1:0] MICROS_PER_SECOND = 32'd1000000;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_MODE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHORDS_IN_USE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHORD_ZERO    = 3'd2;

    typedef struct packed {
        logic load;
        logic match;
        logic eval_load;
        logic eval_check;
        logic finish;
    } bcd_cmd_t;

    typedef struct packed {
        logic eval_none;
        logic idx_last;
        logic out_blocked;
    } bcd_sts_t;

endpackage

[design/button_chord_detector_top.sv]
// ----------------------------------------------------------------------------
// button_chord_detector_top
// Button chord detector: press/release/tick words in, one fire report out.
// ----------------------------------------------------------------------------
// One word is in flight at a time. After accept and button match (all
// entries in parallel), the sweep visits each of the N entries in use, where
// N is chords_in_use saturated to CHORDS. For each entry one step forms
// hold time and delay in microseconds, then the shared compare/update step
// runs. Result hand-off follows; it waits while the previous result is
// still unaccepted. The result sits in an output register, so the next
// word is taken while it waits for the sink. There is
// no clearing pass after reset. Configuration writes belong to idle periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_chord_detector_top
    import bcd_pkg::*;
#(
    parameter int CHORDS            = CHORDS_DEF,
    parameter int BUTTONS_PER_CHORD = BPC_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,   // 0 hold_mode, 1 chords_in_use, 2..5 chords
    input  logic [CHORD_W-1:0]     cfg_wdata,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // button_number[7:0], pressed[8],
                                                  // now_us[40:9], zero fill
    input  logic [0:0]             s_axis_tuser,  // op[0]: 0 button event, 1 recheck tick

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // fired[0], fired_chord[2:1],
                                                  // waiting[3], zero fill
);

    bcd_cmd_t cmd;
    bcd_sts_t sts;

    // sequencer
    bcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // chord state, sweep and output register
    bcd_dp #(
        .CHORDS            (CHORDS),
        .BUTTONS_PER_CHORD (BUTTONS_PER_CHORD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser[0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tdata (m_axis_tdata)
    );

endmodule

[design/bcd_ctrl.sv]
// ----------------------------------------------------------------------------
// bcd_ctrl
// Sequencer: accept, event match, per-entry sweep, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcd_ctrl
    import bcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  bcd_sts_t sts,
    output bcd_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATCH  = 3'd1;
    localparam logic [2:0] S_EVAL_A = 3'd2;
    localparam logic [2:0] S_EVAL_B = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = sts.eval_none ? S_FINISH : S_EVAL_A;
            end
            S_EVAL_A:
            begin
                cmd.eval_load = 1'b1;
                state_next    = S_EVAL_B;
            end
            S_EVAL_B:
            begin
                cmd.eval_check = 1'b1;
                state_next     = sts.idx_last ? S_FINISH : S_EVAL_A;
            end
            S_FINISH:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/bcd_dp.sv]
// ----------------------------------------------------------------------------
// bcd_dp
// Chord state, config registers, match lanes, sweep unit, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcd_dp
    import bcd_pkg::*;
#(
    parameter int CHORDS            = CHORDS_DEF,
    parameter int BUTTONS_PER_CHORD = BPC_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CHORD_W-1:0]     cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  in_tdata,
    input  logic                   in_tuser,
    input  bcd_cmd_t               cmd,
    output bcd_sts_t               sts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_tdata
);

    localparam int CIDX_W = (CHORDS > 1) ? $clog2(CHORDS) : 1;

    function automatic logic slot_hit(input logic [CHORD_W-1:0] cfg, input int s,
                                      input logic [BTN_W-1:0] btn);
        logic [BTN_W-1:0] b;
        b = cfg[s*BTN_W +: BTN_W];
        return (s < BUTTONS_PER_CHORD) && (b != UNSET_BUTTON) && (b == btn);
    endfunction

    // configuration
    logic                 hold_mode_reg;
    logic [2:0]           chords_in_use_reg;
    logic [CHORD_W-1:0]   chord_reg [CHORD_REGS];
    logic [CHORD_W-1:0]   entry_cfg [CHORDS];
    logic [USED_W-1:0]    n_used;
    logic [USED_W-1:0]    ciu_ext;

    // captured item
    logic                 op_reg;
    logic [BTN_W-1:0]     btn_reg;
    logic                 press_reg;
    logic [TIME_W-1:0]    now_reg;

    // chord state
    logic [SLOTS-1:0]     active_reg  [CHORDS];
    logic [SLOTS-1:0]     active_next [CHORDS];
    logic [TIME_W-1:0]    fpt_reg     [CHORDS];
    logic [CHORDS-1:0]    fpt_we;
    logic                 dly_valid_reg, dly_valid_next;
    logic [CIDX_W-1:0]    dly_idx_reg, dly_idx_next;
    logic                 eng_valid_reg, eng_valid_next;
    logic [CIDX_W-1:0]    eng_idx_reg, eng_idx_next;

    // sweep
    logic [CIDX_W-1:0]    idx_reg, idx_next;
    logic [TIME_W-1:0]    held_reg, held_next;
    logic [TIME_W-1:0]    need_reg, need_next;
    logic                 fired_reg, fired_next;
    logic [CIDX_W-1:0]    sec_reg, sec_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    // match lanes
    logic [SLOTS-1:0]     hit   [CHORDS];
    logic [SLOTS-1:0]     first [CHORDS];
    logic [CHORDS-1:0]    in_use;
    logic [CHORD_W-1:0]   eng_cfg;
    logic [CNT_W-1:0]     eng_cnt;
    logic                 rel_hit;
    logic                 hold_clr;
    logic [CHORD_W-1:0]   cur_cfg;
    logic [CNT_W-1:0]     cur_cnt;
    logic [SLOTS-1:0]     cur_mask;
    logic [SLOTS-1:0]     cur_act;

    assign ciu_ext = USED_W'(chords_in_use_reg);
    assign n_used  = (ciu_ext > USED_W'(CHORDS)) ? USED_W'(CHORDS) : ciu_ext;

    for (genvar k = 0; k < CHORDS; k++)
    begin : g_lane
        if (k < CHORD_REGS)
        begin : g_cfg
            assign entry_cfg[k] = chord_reg[k];
        end
        else
        begin : g_zero
            assign entry_cfg[k] = '0;
        end
        for (genvar s = 0; s < SLOTS; s++)
        begin : g_slot
            assign hit[k][s] = slot_hit(entry_cfg[k], s, btn_reg);
        end
        // lowest matching slot only
        assign first[k]  = hit[k] & (~hit[k] + SLOTS'(1));
        assign in_use[k] = (USED_W'(k) < n_used);
    end

    // hold-release test against the engaged chord's leading slots
    assign eng_cfg = entry_cfg[eng_idx_reg];
    assign eng_cnt = eng_cfg[CNT_LSB +: CNT_W];

    always_comb
    begin
        rel_hit = (eng_cnt < CNT_W'(2)) || (int'(eng_cnt) > BUTTONS_PER_CHORD);
        for (int s = 0; s < SLOTS - 1; s++)
        begin
            if ((s + 1 < int'(eng_cnt)) && slot_hit(eng_cfg, s, btn_reg))
            begin
                rel_hit = 1'b1;
            end
        end
    end

    assign hold_clr = hold_mode_reg && !press_reg && eng_valid_reg && rel_hit;

    assign cur_cfg  = entry_cfg[idx_reg];
    assign cur_cnt  = cur_cfg[CNT_LSB +: CNT_W];
    assign cur_mask = (SLOTS'(1) << cur_cnt) - SLOTS'(1);
    assign cur_act  = active_reg[idx_reg];

    always_comb
    begin
        active_next    = active_reg;
        fpt_we         = '0;
        dly_valid_next = dly_valid_reg;
        dly_idx_next   = dly_idx_reg;
        eng_valid_next = eng_valid_reg;
        eng_idx_next   = eng_idx_reg;
        idx_next       = idx_reg;
        held_next      = held_reg;
        need_next      = need_reg;
        fired_next     = fired_reg;
        sec_next       = sec_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            idx_next   = '0;
            fired_next = 1'b0;
            sec_next   = '0;
        end

        if (cmd.match && !op_reg)
        begin
            if (hold_clr)
            begin
                for (int k = 0; k < CHORDS; k++)
                begin
                    if (in_use[k])
                    begin
                        active_next[k] = '0;
                    end
                end
                dly_valid_next = 1'b0;
                dly_idx_next   = '0;
                eng_valid_next = 1'b0;
                eng_idx_next   = '0;
            end
            for (int k = 0; k < CHORDS; k++)
            begin
                if (in_use[k] && (first[k] != '0))
                begin
                    if (press_reg)
                    begin
                        fpt_we[k]      = first[k][0] & ~active_next[k][0];
                        active_next[k] = active_next[k] | first[k];
                    end
                    else
                    begin
                        active_next[k] = active_next[k] & ~first[k];
                        if (first[k][0] && dly_valid_next && (dly_idx_reg == CIDX_W'(k)))
                        begin
                            dly_valid_next = 1'b0;
                            dly_idx_next   = '0;
                        end
                    end
                end
            end
        end

        if (cmd.eval_load)
        begin
            held_next = now_reg - fpt_reg[idx_reg];
            need_next = TIME_W'(cur_cfg[DLY_LSB +: DLY_W]) * MICROS_PER_SECOND;
        end

        if (cmd.eval_check)
        begin
            if ((cur_cnt != '0) && (int'(cur_cnt) <= BUTTONS_PER_CHORD))
            begin
                if (cur_cnt == CNT_W'(1))
                begin
                    if (cur_act[0])
                    begin
                        if ((need_reg == '0) || (held_reg >= need_reg))
                        begin
                            fired_next     = 1'b1;
                            sec_next       = idx_reg;
                            dly_valid_next = 1'b0;
                            dly_idx_next   = '0;
                        end
                        else
                        begin
                            dly_valid_next = 1'b1;
                            dly_idx_next   = idx_reg;
                        end
                    end
                end
                else if ((cur_act & cur_mask) == cur_mask)
                begin
                    fired_next = 1'b1;
                    sec_next   = idx_reg;
                end
            end
            idx_next = idx_reg + CIDX_W'(1);
        end

        if (cmd.finish)
        begin
            if (fired_reg)
            begin
                if (hold_mode_reg)
                begin
                    eng_valid_next = 1'b1;
                    eng_idx_next   = sec_reg;
                end
                else
                begin
                    for (int k = 0; k < CHORDS; k++)
                    begin
                        if (in_use[k])
                        begin
                            active_next[k] = '0;
                        end
                    end
                    dly_valid_next = 1'b0;
                    dly_idx_next   = '0;
                end
            end
            out_valid_next = 1'b1;
            out_data_next  = {dly_valid_next,
                              fired_reg ? 2'(sec_reg) : 2'd0,
                              fired_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_mode_reg     <= 1'b0;
            chords_in_use_reg <= '0;
            for (int k = 0; k < CHORD_REGS; k++)
            begin
                chord_reg[k] <= '0;
            end
            for (int k = 0; k < CHORDS; k++)
            begin
                active_reg[k] <= '0;
            end
            dly_valid_reg <= 1'b0;
            dly_idx_reg   <= '0;
            eng_valid_reg <= 1'b0;
            eng_idx_reg   <= '0;
            idx_reg       <= '0;
            fired_reg     <= 1'b0;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == REG_HOLD_MODE))
            begin
                hold_mode_reg <= cfg_wdata[0];
            end
            if (cfg_we && (cfg_addr == REG_CHORDS_IN_USE))
            begin
                chords_in_use_reg <= cfg_wdata[2:0];
            end
            for (int k = 0; k < CHORD_REGS; k++)
            begin
                if (cfg_we && (cfg_addr == (REG_CHORD_ZERO + CFG_ADDR_W'(k))))
                begin
                    chord_reg[k] <= cfg_wdata;
                end
            end
            active_reg    <= active_next;
            dly_valid_reg <= dly_valid_next;
            dly_idx_reg   <= dly_idx_next;
            eng_valid_reg <= eng_valid_next;
            eng_idx_reg   <= eng_idx_next;
            idx_reg       <= idx_next;
            fired_reg     <= fired_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_tuser;
            btn_reg   <= in_tdata[IN_BTN_LSB +: BTN_W];
            press_reg <= in_tdata[IN_PRESS];
            now_reg   <= in_tdata[IN_NOW_LSB +: TIME_W];
        end
        for (int k = 0; k < CHORDS; k++)
        begin
            if (fpt_we[k])
            begin
                fpt_reg[k] <= now_reg;
            end
        end
        held_reg     <= held_next;
        need_reg     <= need_next;
        out_data_reg <= out_data_next;
    end

    assign sts.eval_none   = (n_used == '0);
    assign sts.idx_last    = ((USED_W'(idx_reg) + USED_W'(1)) == n_used);
    assign sts.out_blocked = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_tdata = {(OUT_TDATA_W - OUT_W)'(0), out_data_reg};

endmodule

[design/bcd_checker.sv]
// ----------------------------------------------------------------------------
// bcd_port_checker
// Port-level checks on the chord detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_chord_detector_top_assert.svh"

module bcd_port_checker
    import bcd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // stalled result word holds
    `BCD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    // chord index is zero unless a chord fired
    `BCD_ASSERT(a_chord_zero, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2:1] == 2'd0, "chord index set without fire")

    // one word in flight: no accept in the cycle after an accept
    `BCD_ASSERT(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted while busy")

    // no result while in reset
    `BCD_ASSERT_RST(a_rst_quiet, !rst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind button_chord_detector_top bcd_port_checker u_bcd_checker (.*);

[bench/bcd_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_tb_pkg
// Bench-side codes and the report word layout for the chord detector bench.
// ----------------------------------------------------------------------------

package bcd_tb_pkg;

    typedef enum logic
    {
        OP_BUTTON = 1'b0,
        OP_TICK   = 1'b1
    } word_op_e;

    // index with no register behind it; writes must be dropped
    localparam logic [bcd_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

    // matches m_axis_tdata[3:0], fired in bit 0
    typedef struct packed {
        logic       waiting;
        logic [1:0] chord;
        logic       fired;
    } chord_report_t;

endpackage

[bench/bcd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_checker
// Watches config writes and both stream channels, predicts each fire report
// and compares it field by field with what the detector sends.
// ----------------------------------------------------------------------------

module bcd_checker
    import bcd_pkg::*;
    import bcd_tb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CHORD_W-1:0]     cfg_wdata,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // button_number, pressed, now_us
    input  logic [0:0]             s_axis_tuser,  // op
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // fired, fired_chord, waiting
    output int                     fail_count,
    output int                     pending
);

    localparam int N_ENTRIES = CHORDS_DEF;

    logic               hold_q;
    logic [2:0]         used_q;
    logic [CHORD_W-1:0] chord_q   [N_ENTRIES];
    logic [SLOTS-1:0]   held_q    [N_ENTRIES];
    logic [TIME_W-1:0]  t_first_q [N_ENTRIES];
    logic               dly_v;
    logic [1:0]         dly_idx;
    logic               eng_v;
    logic [1:0]         eng_idx;
    chord_report_t      expected_reports [$];

    function automatic int live_entries();
        return (int'(used_q) > N_ENTRIES) ? N_ENTRIES : int'(used_q);
    endfunction

    function automatic int chord_len(input int k);
        return int'(chord_q[k][CNT_LSB +: CNT_W]);
    endfunction

    function automatic logic slot_hit(input int k, input int s, input logic [BTN_W-1:0] btn);
        logic [BTN_W-1:0] b;
        if (s >= BPC_DEF)
            return 1'b0;
        b = chord_q[k][BTN_W*s +: BTN_W];
        return (b != UNSET_BUTTON) && (b == btn);
    endfunction

    function automatic int first_slot(input int k, input logic [BTN_W-1:0] btn);
        for (int s = 0; s < SLOTS; s++)
            if (slot_hit(k, s, btn))
                return s;
        return -1;
    endfunction

    // true when releasing btn ends the engagement of chord k
    function automatic logic lead_released(input logic [BTN_W-1:0] btn, input int k);
        int n;
        n = chord_len(k);
        if (n < 2 || n > BPC_DEF)
            return 1'b1;
        for (int s = 0; s < n - 1; s++)
            if (slot_hit(k, s, btn))
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic clear_entries();
        for (int k = 0; k < live_entries(); k++)
        begin
            held_q[k]    = '0;
            t_first_q[k] = '0;
        end
        dly_v   = 1'b0;
        dly_idx = '0;
    endtask

    task automatic predict_word(input word_op_e op, input logic [BTN_W-1:0] btn,
                                input logic press, input logic [TIME_W-1:0] now);
        chord_report_t     rep;
        int                s;
        int                len;
        logic [SLOTS-1:0]  need_mask;
        logic [TIME_W-1:0] need_us;
        rep = '0;
        if (op == OP_BUTTON)
        begin
            if (hold_q && !press && eng_v && lead_released(btn, int'(eng_idx)))
            begin
                clear_entries();
                eng_v   = 1'b0;
                eng_idx = '0;
            end
            for (int k = 0; k < live_entries(); k++)
            begin
                s = first_slot(k, btn);
                if (s < 0)
                    continue;
                if (press)
                begin
                    if (!held_q[k][s])
                    begin
                        held_q[k][s] = 1'b1;
                        if (s == 0)
                            t_first_q[k] = now;
                    end
                end
                else
                begin
                    held_q[k][s] = 1'b0;
                    if (s == 0 && dly_v && dly_idx == k)
                    begin
                        dly_v   = 1'b0;
                        dly_idx = '0;
                    end
                end
            end
        end

        for (int k = 0; k < live_entries(); k++)
        begin
            len = chord_len(k);
            if (len < 1 || len > BPC_DEF)
                continue;
            need_mask = SLOTS'((1 << len) - 1);
            if (len == 1)
            begin
                if (held_q[k][0])
                begin
                    need_us = 32'(chord_q[k][DLY_LSB +: DLY_W]) * MICROS_PER_SECOND;
                    if (need_us == 0 || (now - t_first_q[k]) >= need_us)
                    begin
                        rep.fired = 1'b1;
                        rep.chord = 2'(k);
                        dly_v     = 1'b0;
                        dly_idx   = '0;
                    end
                    else
                    begin
                        dly_v   = 1'b1;
                        dly_idx = 2'(k);
                    end
                end
            end
            else if ((held_q[k] & need_mask) == need_mask)
            begin
                rep.fired = 1'b1;
                rep.chord = 2'(k);
            end
        end

        if (rep.fired)
        begin
            if (hold_q)
            begin
                eng_v   = 1'b1;
                eng_idx = rep.chord;
            end
            else
                clear_entries();
        end
        rep.waiting = dly_v;
        expected_reports.push_back(rep);
    endtask

    task automatic check_report(input logic [OUT_TDATA_W-1:0] word);
        chord_report_t want;
        chord_report_t got;
        got = word[OUT_W-1:0];
        if (expected_reports.size() == 0)
        begin
            $error("report word %h with no expectation pending", word);
            fail_count++;
            return;
        end
        want = expected_reports.pop_front();
        if (got.fired !== want.fired)
        begin
            $error("fired: expected %0d, got %0d", want.fired, got.fired);
            fail_count++;
        end
        if (got.chord !== want.chord)
        begin
            $error("fired_chord: expected %0d, got %0d", want.chord, got.chord);
            fail_count++;
        end
        if (got.waiting !== want.waiting)
        begin
            $error("waiting: expected %0d, got %0d", want.waiting, got.waiting);
            fail_count++;
        end
        if (word[OUT_TDATA_W-1:OUT_W] !== '0)
        begin
            $error("zero fill: expected 0, got %h", word[OUT_TDATA_W-1:OUT_W]);
            fail_count++;
        end
    endtask

    task automatic apply_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CHORD_W-1:0] data);
        if (addr == REG_HOLD_MODE)
            hold_q = data[0];
        else if (addr == REG_CHORDS_IN_USE)
            used_q = data[2:0];
        else if (addr >= REG_CHORD_ZERO && addr < REG_CHORD_ZERO + CHORD_REGS)
            chord_q[addr - REG_CHORD_ZERO] = data;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_q  = 1'b0;
            used_q  = '0;
            dly_v   = 1'b0;
            dly_idx = '0;
            eng_v   = 1'b0;
            eng_idx = '0;
            for (int k = 0; k < N_ENTRIES; k++)
            begin
                chord_q[k]   = '0;
                held_q[k]    = '0;
                t_first_q[k] = '0;
            end
            expected_reports.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            // a report leaving on this edge always belongs to an older word
            if (m_axis_tvalid && m_axis_tready)
                check_report(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                predict_word(word_op_e'(s_axis_tuser[0]),
                             s_axis_tdata[IN_BTN_LSB +: BTN_W],
                             s_axis_tdata[IN_PRESS],
                             s_axis_tdata[IN_NOW_LSB +: TIME_W]);
            if (cfg_we)
                apply_write(cfg_addr, cfg_wdata);
            pending <= expected_reports.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Chord detector bench: directed press/release/tick words, then phases of
// random chord sequences under changing config, with bursty input and a
// stalling sink. bcd_checker predicts and compares every report word.
// ----------------------------------------------------------------------------

module tb_top;
    import bcd_pkg::*;
    import bcd_tb_pkg::*;

    localparam int         N_ENTRIES   = CHORDS_DEF;
    localparam int         PHASES      = 8;
    localparam int         PHASE_WORDS = 80;
    localparam int         LONG_STALL  = 200;            // sink hold-off, cycles
    localparam int         SETTLE      = 2 * N_ENTRIES + 3 + 4;
    localparam int         DRAIN_LIMIT = 20000;
    localparam int         TIMEOUT_NS  = 5_000_000;
    localparam logic [7:0] POOL_MAX    = 8'd11;          // buttons used by chords

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CHORD_W-1:0]     cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int                     fail_count;
    int                     pending;

    // stimulus bookkeeping
    int                     items_sent;
    int                     burst_left;
    int                     stall_requests;
    int                     stall_served;
    logic [TIME_W-1:0]      clock_us;
    logic [CHORD_W-1:0]     cfg_chord [N_ENTRIES];

    always #5 clk = ~clk;

    button_chord_detector_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bcd_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // chord register layout: slots in bytes 0..3, count 34:32, delay 42:35
    function automatic logic [CHORD_W-1:0] pack_chord(input logic [7:0] b0, input logic [7:0] b1,
                                                      input logic [7:0] b2, input logic [7:0] b3,
                                                      input logic [2:0] len, input logic [7:0] secs);
        return {secs, len, b3, b2, b1, b0};
    endfunction

    // Mostly sane chords over a small button pool so that random sequences
    // actually complete them; now and then all zeros, all ones, odd counts,
    // unset slots and long delays.
    function automatic logic [CHORD_W-1:0] random_chord();
        logic [7:0] b [SLOTS];
        logic [2:0] len;
        logic [7:0] secs;
        int         pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        for (int s = 0; s < SLOTS; s++)
            b[s] = ($urandom_range(0, 7) == 0) ? UNSET_BUTTON : 8'($urandom_range(0, POOL_MAX));
        len  = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(1, SLOTS)) : 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 19);
        if (pick < 11)
            secs = 8'd0;
        else if (pick < 19)
            secs = 8'($urandom_range(1, 2));
        else
            secs = 8'($urandom_range(3, 255));
        return pack_chord(b[0], b[1], b[2], b[3], len, secs);
    endfunction

    // One register write, launched on a falling edge, held for one cycle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CHORD_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Writes every register. junk fills the unused upper bits of the two
    // narrow registers, which the block has to ignore.
    task automatic load_setup(input logic hold, input logic [2:0] used,
                              input logic [CHORD_W-1:0] c0, input logic [CHORD_W-1:0] c1,
                              input logic [CHORD_W-1:0] c2, input logic [CHORD_W-1:0] c3,
                              input logic [CHORD_W-1:0] junk);
        write_reg(REG_HOLD_MODE, {junk[CHORD_W-1:1], hold});
        write_reg(REG_CHORDS_IN_USE, {junk[CHORD_W-1:3], used});
        cfg_chord[0] = c0;
        cfg_chord[1] = c1;
        cfg_chord[2] = c2;
        cfg_chord[3] = c3;
        for (int k = 0; k < N_ENTRIES; k++)
            write_reg(REG_CHORD_ZERO + CFG_ADDR_W'(k), cfg_chord[k]);
    endtask

    // Offer one word and block until it is taken. The sender runs in bursts:
    // when a burst is used up, valid drops for a random gap (often none).
    // Back-to-back words keep valid high without a dip.
    task automatic send_word(input word_op_e op, input logic [BTN_W-1:0] btn,
                             input logic press, input logic [TIME_W-1:0] now);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tdata                         = '0;
        s_axis_tdata[IN_BTN_LSB +: BTN_W]    = btn;
        s_axis_tdata[IN_PRESS]               = press;
        s_axis_tdata[IN_NOW_LSB +: TIME_W]   = now;
        s_axis_tuser                         = op;
        s_axis_tvalid                        = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // Drop valid and wait until every report has been seen, then give the
    // block its per-word latency so nothing is left in flight.
    task automatic wait_idle();
        int guard;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        burst_left    = 0;
        guard         = 0;
        while (pending != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // Time moves forward by a random step; now and then it jumps anywhere,
    // which also walks the counter across the 32-bit wrap.
    task automatic advance_clock(input int unsigned max_step);
        if ($urandom_range(0, 19) == 0)
            clock_us = $urandom();
        else
            clock_us = clock_us + $urandom_range(0, max_step);
    endtask

    // Noise word: any button, any direction, sometimes a tick.
    task automatic random_word();
        logic [7:0] btn;
        word_op_e   op;
        btn = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, POOL_MAX));
        op  = ($urandom_range(0, 4) == 0) ? OP_TICK : OP_BUTTON;
        advance_clock(($urandom_range(0, 3) == 0) ? 1_500_000 : 40_000);
        send_word(op, btn, 1'($urandom_range(0, 1)), clock_us);
    endtask

    // Well-formed chord: press the buttons of one entry in slot order, give
    // a few ticks for delayed singles, then usually release in a rotated
    // order (sometimes left held so state piles up across runs).
    task automatic chord_run();
        int                 k;
        int                 len;
        int                 first;
        logic [CHORD_W-1:0] c;
        k   = $urandom_range(0, N_ENTRIES - 1);
        c   = cfg_chord[k];
        len = int'(c[CNT_LSB +: CNT_W]);
        if (len < 1 || len > SLOTS)
            len = $urandom_range(1, SLOTS);
        for (int i = 0; i < len; i++)
        begin
            advance_clock(30_000);
            send_word(OP_BUTTON, c[BTN_W*i +: BTN_W], 1'b1, clock_us);
        end
        repeat ($urandom_range(0, 3))
        begin
            advance_clock(1_200_000);
            send_word(OP_TICK, 8'($urandom()), 1'($urandom()), clock_us);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            first = $urandom_range(0, len - 1);
            for (int i = 0; i < len; i++)
            begin
                advance_clock(30_000);
                send_word(OP_BUTTON, c[BTN_W*((first + i) % len) +: BTN_W], 1'b0, clock_us);
            end
        end
    endtask

    // Sink: ready follows one of four patterns in turn (always, coin flip,
    // one in four, mostly ready). A request from the stimulus makes it hold
    // ready low for a LONG_STALL hold-off so the block backs up.
    initial
    begin : sink
        int cyc;
        cyc           = 0;
        stall_served  = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (stall_served != stall_requests)
            begin
                stall_served++;
                m_axis_tready = 1'b0;
                repeat (LONG_STALL) @(negedge clk);
            end
            case ((cyc / 97) % 4)
                0:       m_axis_tready = 1'b1;
                1:       m_axis_tready = 1'($urandom_range(0, 1));
                2:       m_axis_tready = (cyc % 4 == 0);
                default: m_axis_tready = ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    initial
    begin : stimulus
        int               goal;
        logic [2:0]       used_pick [PHASES];
        logic [2:0]       used;
        logic [TIME_W-1:0] t0;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        items_sent     = 0;
        burst_left     = 0;
        stall_requests = 0;
        clock_us       = '0;
        for (int k = 0; k < N_ENTRIES; k++)
            cfg_chord[k] = '0;
        // chords_in_use per random phase: full, one, saturating, two, none, ...
        used_pick = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd5, 3'd4};

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // After reset no entry is in use, so nothing can match or fire.
        send_word(OP_BUTTON, 8'd0, 1'b1, 32'd0);
        wait_idle();

        // ---- plain mode, all four entries ----
        // 0: buttons 1+2, 1: button 5 held one second, 2: buttons 7..10,
        // 3: button 3 alone (listed twice; only the first slot counts)
        load_setup(1'b0, 3'd4,
                   pack_chord(8'd1, 8'd2, UNSET_BUTTON, UNSET_BUTTON, 3'd2, 8'd0),
                   pack_chord(8'd5, UNSET_BUTTON, UNSET_BUTTON, UNSET_BUTTON, 3'd1, 8'd1),
                   pack_chord(8'd7, 8'd8, 8'd9, 8'd10, 3'd4, 8'd0),
                   pack_chord(8'd3, UNSET_BUTTON, 8'd3, UNSET_BUTTON, 3'd1, 8'd0),
                   '0);
        send_word(OP_BUTTON, 8'd1, 1'b1, 32'd100);
        send_word(OP_BUTTON, 8'd2, 1'b1, 32'd200);          // pair fires, all clear
        send_word(OP_BUTTON, 8'd3, 1'b1, 32'd300);          // single, no delay
        send_word(OP_BUTTON, 8'd3, 1'b0, 32'd400);
        // delayed single whose hold time crosses the 32-bit wrap
        t0 = 32'hFFFF_0000;
        send_word(OP_BUTTON, 8'd5, 1'b1, t0);               // waiting raised
        send_word(OP_TICK,   8'd0, 1'b0, t0 + 32'd999_999);  // one short
        send_word(OP_TICK,   8'hFF, 1'b1, t0 + 32'd1_000_000); // fires
        send_word(OP_BUTTON, 8'd5, 1'b1, 32'd10);
        send_word(OP_BUTTON, 8'd5, 1'b0, 32'd20);           // release cancels delay
        send_word(OP_BUTTON, 8'd7, 1'b1, 32'd30);
        send_word(OP_BUTTON, 8'd8, 1'b1, 32'd40);
        send_word(OP_BUTTON, 8'd9, 1'b1, 32'd50);
        send_word(OP_BUTTON, 8'd10, 1'b1, 32'hFFFF_FFFF);   // four-button chord
        send_word(OP_BUTTON, UNSET_BUTTON, 1'b1, 32'd60);   // 255 never matches
        wait_idle();

        // ---- hold mode, in-use count above CHORDS ----
        // 1: button 5 with the longest delay, 2: all ones (count 7, never
        // fires), 3: button 4 alone
        load_setup(1'b1, 3'd7,
                   pack_chord(8'd1, 8'd2, UNSET_BUTTON, UNSET_BUTTON, 3'd2, 8'd0),
                   pack_chord(8'd5, UNSET_BUTTON, UNSET_BUTTON, UNSET_BUTTON, 3'd1, 8'd255),
                   '1,
                   pack_chord(8'd4, UNSET_BUTTON, UNSET_BUTTON, UNSET_BUTTON, 3'd1, 8'd0),
                   '1);
        write_reg(REG_UNMAPPED, '1);                        // must be dropped
        send_word(OP_BUTTON, 8'd1, 1'b1, 32'd1000);
        send_word(OP_BUTTON, 8'd2, 1'b1, 32'd1100);         // engage pair
        send_word(OP_BUTTON, 8'd4, 1'b1, 32'd1200);         // both fire, last one wins
        send_word(OP_BUTTON, 8'd2, 1'b0, 32'd1300);         // single engaged: any release clears
        send_word(OP_BUTTON, 8'd5, 1'b1, 32'd2000);
        send_word(OP_TICK,   8'd0, 1'b0, 32'd2000 + 32'd255_000_000);
        send_word(OP_BUTTON, 8'd5, 1'b0, 32'd255_100_000);
        send_word(OP_BUTTON, 8'd1, 1'b1, 32'd255_200_000);
        send_word(OP_BUTTON, 8'd2, 1'b1, 32'd255_300_000);  // engage pair again
        send_word(OP_BUTTON, 8'd2, 1'b0, 32'd255_400_000);  // not a leading button
        send_word(OP_BUTTON, 8'd1, 1'b0, 32'd255_500_000);  // leading button: clear

        // ---- random phases ----
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            used = used_pick[p];
            load_setup(1'(p % 2), used, random_chord(), random_chord(), random_chord(),
                       random_chord(), {$urandom(), $urandom()});
            clock_us = $urandom();
            // one long sink hold-off while words keep coming
            if (p == 2)
                stall_requests++;
            goal = items_sent + PHASE_WORDS;
            while (items_sent < goal)
            begin
                // sender pauses once mid-phase until the block has drained
                if (p == 5 && items_sent == goal - PHASE_WORDS / 2)
                    wait_idle();
                if ($urandom_range(0, 9) < 6)
                    chord_run();
                else
                    random_word();
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/bcd_pkg.sv
design/bcd_ctrl.sv
design/bcd_dp.sv
design/button_chord_detector_top.sv
design/bcd_checker.sv
bench/bcd_tb_pkg.sv
bench/bcd_checker.sv
bench/tb_top.sv
